>>> rtl/slr_pkg.sv
// Shared types and constants of the slope limiter pipeline.
// No dependencies.
package slr_pkg;

    localparam int VAL_W   = 32;               // input cell value width
    localparam int DIFF_W  = VAL_W + 1;        // one-sided difference width
    localparam int OUT_W   = VAL_W + 2;        // slope and face width
    localparam int PROD_W  = 2 * VAL_W;        // product of magnitudes
    localparam int QUOT_W  = DIFF_W;           // quotient bits of 2*prod/sum
    localparam int DIV_LAT = QUOT_W;           // one quotient bit per stage

    typedef enum logic [1:0] {
        MODE_MC = 2'd0,
        MODE_VL = 2'd1,
        MODE_MM = 2'd2,
        MODE_XX = 2'd3
    } mode_t;

    // Data that rides along the divider next to the division itself.
    typedef struct packed {
        logic                    use_vl;
        logic                    neg;
        logic signed [OUT_W-1:0] alt_slope;
        logic signed [VAL_W-1:0] centre;
    } side_t;

    function automatic logic [OUT_W-1:0] mag34(input logic signed [OUT_W-1:0] v);
        logic [OUT_W-1:0] r;
        r = v[OUT_W-1] ? OUT_W'(-v) : OUT_W'(v);
        return r;
    endfunction

endpackage

>>> rtl/slr_front.sv
// Front stages: differences, MC and minmod choice, magnitude product for van Leer.
// Depends on slr_pkg.
module slr_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  slr_pkg::mode_t                mode,
    input  logic signed [31:0]            left_value,
    input  logic signed [31:0]            centre_value,
    input  logic signed [31:0]            right_value,
    output logic                          out_valid,
    output logic [slr_pkg::PROD_W-1:0]    prod,
    output logic [slr_pkg::DIFF_W-1:0]    sum,
    output slr_pkg::side_t                side
);
    import slr_pkg::*;

    // stage 1: captured inputs
    logic                    v1_reg;
    mode_t                   mode1_reg;
    logic signed [VAL_W-1:0] l1_reg, c1_reg, r1_reg;

    // stage 2: differences
    logic                     v2_reg;
    mode_t                    mode2_reg;
    logic signed [VAL_W-1:0]  c2_reg;
    logic signed [DIFF_W-1:0] dm2_reg, dp2_reg, span2_reg;

    // stage 3: limiter choice and magnitudes
    logic             v3_reg;
    logic [VAL_W-1:0] a3_reg, b3_reg;
    side_t            side3_reg;

    // stage 4: product
    logic              v4_reg;
    logic [PROD_W-1:0] prod4_reg;
    logic [DIFF_W-1:0] sum4_reg;
    side_t             side4_reg;

    logic signed [DIFF_W-1:0] dm_next, dp_next, span_next;
    logic                     same;
    logic signed [OUT_W-1:0]  qm, qp, qc, mc_slope, mm_slope, dm_x, dp_x;
    logic [OUT_W-1:0]         mag_qm, mag_qp, mag_qc, mag_dm, mag_dp;
    side_t                    side3_next;

    always_comb
    begin
        dm_next   = DIFF_W'(c1_reg) - DIFF_W'(l1_reg);
        dp_next   = DIFF_W'(r1_reg) - DIFF_W'(c1_reg);
        span_next = DIFF_W'(r1_reg) - DIFF_W'(l1_reg);
    end

    always_comb
    begin
        same = (dm2_reg != '0) && (dp2_reg != '0) && (dm2_reg[DIFF_W-1] == dp2_reg[DIFF_W-1]);
        dm_x = OUT_W'(dm2_reg);
        dp_x = OUT_W'(dp2_reg);
        qm   = dm_x <<< 1;
        qp   = dp_x <<< 1;
        qc   = OUT_W'(span2_reg >>> 1);
        mag_qm = mag34(qm);
        mag_qp = mag34(qp);
        mag_qc = mag34(qc);
        mag_dm = mag34(dm_x);
        mag_dp = mag34(dp_x);
        if (mag_qm < mag_qp && mag_qm < mag_qc)
            mc_slope = qm;
        else if (mag_qp < mag_qc)
            mc_slope = qp;
        else
            mc_slope = qc;
        mm_slope = (mag_dm < mag_dp) ? dm_x : dp_x;

        side3_next.use_vl = same && (mode2_reg == MODE_VL);
        side3_next.neg    = dm2_reg[DIFF_W-1];
        side3_next.centre = c2_reg;
        unique case (mode2_reg)
            MODE_MC: side3_next.alt_slope = same ? mc_slope : '0;
            MODE_VL: side3_next.alt_slope = '0;
            default: side3_next.alt_slope = same ? mm_slope : '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mode1_reg <= mode;
        l1_reg    <= left_value;
        c1_reg    <= centre_value;
        r1_reg    <= right_value;

        mode2_reg <= mode1_reg;
        c2_reg    <= c1_reg;
        dm2_reg   <= dm_next;
        dp2_reg   <= dp_next;
        span2_reg <= span_next;

        a3_reg    <= mag_dm[VAL_W-1:0];
        b3_reg    <= mag_dp[VAL_W-1:0];
        side3_reg <= side3_next;

        prod4_reg <= a3_reg * b3_reg;
        sum4_reg  <= DIFF_W'(a3_reg) + DIFF_W'(b3_reg);
        side4_reg <= side3_reg;
    end

    assign out_valid = v4_reg;
    assign prod      = prod4_reg;
    assign sum       = sum4_reg;
    assign side      = side4_reg;

endmodule

>>> rtl/slr_div.sv
// Pipelined restoring divider, one quotient bit per stage: floor(2*prod/sum).
// Depends on slr_pkg.
module slr_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [slr_pkg::PROD_W-1:0]    prod,
    input  logic [slr_pkg::DIFF_W-1:0]    sum,
    input  slr_pkg::side_t                side_in,
    output logic                          out_valid,
    output logic [slr_pkg::QUOT_W-1:0]    quot,
    output slr_pkg::side_t                side_out
);
    import slr_pkg::*;

    localparam int N = DIV_LAT;

    logic              v_reg    [0:N-1];
    logic [DIFF_W-1:0] rem_reg  [0:N-1];
    logic [DIFF_W-1:0] nlo_reg  [0:N-1];
    logic [QUOT_W-1:0] q_reg    [0:N-1];
    logic [DIFF_W-1:0] den_reg  [0:N-1];
    side_t             side_reg [0:N-1];

    logic              v_in    [0:N-1];
    logic [DIFF_W-1:0] rem_in  [0:N-1];
    logic [DIFF_W-1:0] nlo_in  [0:N-1];
    logic [QUOT_W-1:0] q_in    [0:N-1];
    logic [DIFF_W-1:0] den_in  [0:N-1];
    side_t             side_in_s [0:N-1];

    // numerator 2*prod: its top bits start the remainder, below sum whenever sum is nonzero
    assign v_in[0]      = in_valid;
    assign rem_in[0]    = DIFF_W'(prod[PROD_W-1:VAL_W]);
    assign nlo_in[0]    = {prod[VAL_W-1:0], 1'b0};
    assign q_in[0]      = '0;
    assign den_in[0]    = sum;
    assign side_in_s[0] = side_in;

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_stage
            logic [DIFF_W:0] t;
            logic            ge;

            if (k > 0)
            begin : g_link
                assign v_in[k]      = v_reg[k-1];
                assign rem_in[k]    = rem_reg[k-1];
                assign nlo_in[k]    = nlo_reg[k-1];
                assign q_in[k]      = q_reg[k-1];
                assign den_in[k]    = den_reg[k-1];
                assign side_in_s[k] = side_reg[k-1];
            end

            always_comb
            begin
                t  = {rem_in[k], nlo_in[k][DIFF_W-1]};
                ge = (t >= {1'b0, den_in[k]});
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[k] <= 1'b0;
                else
                    v_reg[k] <= v_in[k];
            end

            always_ff @(posedge clk)
            begin
                rem_reg[k]  <= ge ? DIFF_W'(t - {1'b0, den_in[k]}) : t[DIFF_W-1:0];
                nlo_reg[k]  <= {nlo_in[k][DIFF_W-2:0], 1'b0};
                q_reg[k]    <= {q_in[k][QUOT_W-2:0], ge};
                den_reg[k]  <= den_in[k];
                side_reg[k] <= side_in_s[k];
            end
        end
    endgenerate

    assign out_valid = v_reg[N-1];
    assign quot      = q_reg[N-1];
    assign side_out  = side_reg[N-1];

endmodule

>>> rtl/slope_limiter_reconstruct.sv
// TVD slope limiter (MC, van Leer, minmod) with linear face reconstruction.
// Depends on slr_pkg, slr_front, slr_div.
//
// One item (three neighboring Q16.16 cells) is taken on every cycle that start
// is high; busy is never raised. Each item yields one result, shown for one
// cycle with done high, that has passed four front stages (inputs, differences,
// limiter choice, 32x32 product), 33 stages of a bit-per-stage van Leer divider
// and one output register. The receiver cannot stall the block. Write
// limiter_mode through cfg_we/cfg_data only while no items are in flight.
module slope_limiter_reconstruct (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] left_value,
    input  logic signed [31:0] centre_value,
    input  logic signed [31:0] right_value,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_data,
    output logic               done,
    output logic signed [33:0] limited_slope,
    output logic signed [33:0] left_face,
    output logic signed [33:0] right_face
);
    import slr_pkg::*;

    localparam int LAT = 4 + DIV_LAT + 1;

    mode_t             mode_reg;
    logic              f_valid, d_valid;
    logic [PROD_W-1:0] f_prod;
    logic [DIFF_W-1:0] f_sum;
    side_t             f_side, d_side;
    logic [QUOT_W-1:0] d_quot;

    logic                    done_reg;
    logic signed [OUT_W-1:0] slope_reg, lface_reg, rface_reg;
    logic signed [OUT_W-1:0] vl_slope, slope_next, half;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_MC;
        else if (cfg_we)
            mode_reg <= mode_t'(cfg_data);
    end

    slr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (start),
        .mode         (mode_reg),
        .left_value   (left_value),
        .centre_value (centre_value),
        .right_value  (right_value),
        .out_valid    (f_valid),
        .prod         (f_prod),
        .sum          (f_sum),
        .side         (f_side)
    );

    slr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .prod      (f_prod),
        .sum       (f_sum),
        .side_in   (f_side),
        .out_valid (d_valid),
        .quot      (d_quot),
        .side_out  (d_side)
    );

    always_comb
    begin
        vl_slope   = d_side.neg ? -OUT_W'(d_quot) : OUT_W'(d_quot);
        slope_next = d_side.use_vl ? vl_slope : d_side.alt_slope;
        half       = slope_next >>> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= d_valid;
    end

    always_ff @(posedge clk)
    begin
        slope_reg <= slope_next;
        lface_reg <= OUT_W'(d_side.centre) - half;
        rface_reg <= OUT_W'(d_side.centre) + half;
    end

    assign busy          = 1'b0;
    assign done          = done_reg;
    assign limited_slope = slope_reg;
    assign left_face     = lface_reg;
    assign right_face    = rface_reg;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without an item LAT cycles earlier");

    a_faces_span: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (right_face - left_face) == ((limited_slope >>> 1) <<< 1))
        else $error("faces not symmetric about the centre");

    a_slope_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> limited_slope != {1'b1, {(OUT_W-1){1'b0}}})
        else $error("slope out of range");
`endif

endmodule

>>> dv/slope_limiter_reconstruct_test.sv
// Testbench for slope_limiter_reconstruct: directed and random cell triples
// checked against an in-bench limiter predictor. Depends on slr_pkg and the RTL.
module slope_limiter_reconstruct_test;
    import slr_pkg::*;

    typedef struct {
        logic signed [31:0] l;
        logic signed [31:0] c;
        logic signed [31:0] r;
        int                 gap;
    } cell_item_t;

    typedef struct {
        logic signed [33:0] slope;
        logic signed [33:0] lf;
        logic signed [33:0] rf;
    } face_set_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [31:0] left_value = '0;
    logic signed [31:0] centre_value = '0;
    logic signed [31:0] right_value = '0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_data = '0;
    logic done;
    logic signed [33:0] limited_slope, left_face, right_face;

    cell_item_t pending_cells[$];
    face_set_t  expected_faces[$];
    mode_t      cur_mode = MODE_MC;
    int         mismatches = 0;
    int         checked = 0;
    int         idle_cycles = 0;
    int         gap_left = 0;
    bit         feeding = 1'b0;

    slope_limiter_reconstruct uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .left_value(left_value), .centre_value(centre_value),
        .right_value(right_value), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .done(done), .limited_slope(limited_slope), .left_face(left_face),
        .right_face(right_face)
    );

    always #5 clk = ~clk;

    function automatic longint half_down(longint v);
        return v >>> 1;
    endfunction

    function automatic longint absval(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic face_set_t predict_faces(mode_t m, cell_item_t it);
        longint    l, c, r, dm, dp, s, qm, qp, qc, a, b, sum, prod, q, rem, h;
        face_set_t f;
        l = it.l;
        c = it.c;
        r = it.r;
        dm = c - l;
        dp = r - c;
        s = 0;
        if ((dm > 0 && dp > 0) || (dm < 0 && dp < 0))
        begin
            if (m == MODE_MC)
            begin
                qm = 2 * dm;
                qp = 2 * dp;
                qc = half_down(r - l);
                if (absval(qm) < absval(qp) && absval(qm) < absval(qc))
                    s = qm;
                else if (absval(qp) < absval(qc))
                    s = qp;
                else
                    s = qc;
            end
            else if (m == MODE_VL)
            begin
                a = absval(dm);
                b = absval(dp);
                sum = a + b;
                // product can exceed 2^63: use unsigned 64-bit math
                q = longint'(64'(unsigned'(a) * unsigned'(b)) / 64'(unsigned'(sum)));
                rem = longint'(64'(unsigned'(a) * unsigned'(b)) % 64'(unsigned'(sum)));
                s = 2 * q + ((2 * rem >= sum) ? 1 : 0);
                if (dm < 0)
                    s = -s;
            end
            else
                s = absval(dm) < absval(dp) ? dm : dp;
        end
        h = half_down(s);
        f.slope = 34'(s);
        f.lf = 34'(c - h);
        f.rf = 34'(c + h);
        return f;
    endfunction

    // driver
    always @(negedge clk)
    begin
        cell_item_t it;
        if (feeding && !(start && busy) && gap_left == 0 && pending_cells.size() > 0)
        begin
            it = pending_cells.pop_front();
            left_value <= it.l;
            centre_value <= it.c;
            right_value <= it.r;
            start <= 1'b1;
            expected_faces.push_back(predict_faces(cur_mode, it));
            gap_left <= it.gap;
        end
        else
        begin
            if (start && !busy)
                start <= 1'b0;
            if (feeding && !(start && busy) && gap_left > 0)
                gap_left <= gap_left - 1;
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        face_set_t e;
        if (done)
        begin
            idle_cycles <= 0;
            if (expected_faces.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result slope=%0d", limited_slope);
            end
            else
            begin
                e = expected_faces.pop_front();
                checked++;
                if (e.slope !== limited_slope || e.lf !== left_face
                    || e.rf !== right_face)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch mode=%0d exp %0d/%0d/%0d got %0d/%0d/%0d",
                                 cur_mode, e.slope, e.lf, e.rf,
                                 limited_slope, left_face, right_face);
                end
            end
        end
        else if (start && !busy)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000)
        begin
            $display("slope_limiter_reconstruct verification failed");
            $finish;
        end
    end

    function automatic logic signed [31:0] rand_val();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff - $urandom_range(0, 3);
            1: return 32'sh80000000 + $urandom_range(0, 3);
            2: return 32'($urandom_range(0, 200)) - 100;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_cell(logic signed [31:0] l, c, r, bit nogap);
        cell_item_t it;
        it.l = l;
        it.c = c;
        it.r = r;
        it.gap = nogap ? 0 : $urandom_range(0, 12);
        pending_cells.push_back(it);
    endtask

    task automatic add_random(int n);
        logic signed [31:0] c;
        bit nogap;
        nogap = $urandom_range(0, 3) == 0;
        repeat (n)
        begin
            c = rand_val();
            if ($urandom_range(0, 3) != 0)
            begin
                // monotone triple (unless an offset wraps) so the limiters do real work
                if ($urandom_range(0, 1))
                    add_cell(c - $urandom_range(1, 1 << $urandom_range(0, 30)), c,
                             c + $urandom_range(1, 1 << $urandom_range(0, 30)), nogap);
                else
                    add_cell(c + $urandom_range(1, 1 << $urandom_range(0, 30)), c,
                             c - $urandom_range(1, 1 << $urandom_range(0, 30)), nogap);
            end
            else
                add_cell(rand_val(), c, rand_val(), nogap);
        end
    endtask

    task automatic run_phase();
        feeding = 1'b1;
        wait (pending_cells.size() == 0);
        @(negedge clk);
        feeding = 1'b0;
        wait (expected_faces.size() == 0);
        repeat (45) @(negedge clk);
    endtask

    task automatic set_mode(mode_t m);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= m;
        @(negedge clk);
        cfg_we <= 1'b0;
        cur_mode = m;
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        for (int m = 0; m < 3; m++)
        begin
            if (m != 0)
                set_mode(mode_t'(m));
            add_cell(32'sh80000000, 32'sh00000000, 32'sh7fffffff, 1'b0);
            add_cell(32'sh7fffffff, 32'sh00000000, 32'sh80000000, 1'b0);
            add_cell(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 1'b1);
            add_cell(32'sh80000000, 32'sh80000001, 32'sh7fffffff, 1'b1);
            add_cell(32'sh7fffffff, 32'sh7ffffffe, 32'sh80000000, 1'b0);
            add_cell(32'sd10, 32'sd5, 32'sd20, 1'b0);
            add_cell(32'sd0, 32'sd3, 32'sd4, 1'b1);
            add_cell(-32'sd3, -32'sd2, 32'sd5, 1'b0);
            run_phase();
        end
        set_mode(MODE_MC);
        for (int p = 0; p < 9; p++)
        begin
            set_mode(mode_t'($urandom_range(0, 2)));
            add_random(150);
            run_phase();
        end
        $display("checked %0d results over three limiter modes, extremes and random cells",
                 checked);
        if (mismatches == 0 && expected_faces.size() == 0)
            $display("slope_limiter_reconstruct verification clean");
        else
            $display("slope_limiter_reconstruct verification failed");
        $finish;
    end
endmodule

>>> sim.f
rtl/slr_pkg.sv
rtl/slr_front.sv
rtl/slr_div.sv
rtl/slope_limiter_reconstruct.sv
dv/slope_limiter_reconstruct_test.sv
